// ===== rtl/spse_pkg.sv =====
`default_nettype none

package spse_pkg;

	// Permutation geometry.
	localparam int TBL_DEPTH = 256;
	localparam int TBL_AW = 8;

	// Absorb constants.
	localparam logic [7:0] HALF_POINT = 8'd128;
	localparam logic [7:0] NIBBLE_MASK = 8'h0f;
	localparam logic [7:0] STRIDE_RESET = 8'd1;
	localparam logic [7:0] STRIDE_STEP = 8'd2;

	// Mode codes carried in tuser.
	localparam logic [2:0] MODE_INIT = 3'd0;
	localparam logic [2:0] MODE_ABSORB = 3'd1;
	localparam logic [2:0] MODE_STOP = 3'd2;
	localparam logic [2:0] MODE_DRIP = 3'd3;
	localparam logic [2:0] MODE_ENCRYPT = 3'd4;
	localparam logic [2:0] MODE_DECRYPT = 3'd5;
	localparam logic [2:0] MODE_PEEK = 3'd6;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_A_CHK,
		ST_A_R1,
		ST_A_R2,
		ST_A_W1,
		ST_A_W2,
		ST_STOP,
		ST_STOP_FIN,
		ST_KEY,
		ST_U_RI,
		ST_U_RY,
		ST_U_RJ,
		ST_U_W1,
		ST_U_W2,
		ST_O_R1,
		ST_O_R2,
		ST_O_R3,
		ST_O_R4,
		ST_EMIT
	} seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/spse_ram.sv =====
`default_nettype none

module spse_ram
	#(
		parameter int WIDTH = 8,
		parameter int DEPTH = 256
	)
	(
		input  wire logic                     clk,
		input  wire logic                     we,
		input  wire logic [$clog2(DEPTH)-1:0] waddr,
		input  wire logic [WIDTH-1:0]         wdata,
		input  wire logic [$clog2(DEPTH)-1:0] raddr,
		output logic      [WIDTH-1:0]         rdata
	);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/spritz_sponge_engine_top.sv =====
// Sponge engine over a 256-byte permutation held in one RAM with a registered read.
// A shuffle runs WHIP_ROUNDS table updates within the word that triggers it.
// Reset and init clear the per-entry valid bits at once, so the table reads as the
// identity with no clearing pass; all index registers return to their reset values.
`default_nettype none

module spritz_sponge_engine_top
	import spse_pkg::*;
	#(
		parameter int WHIP_ROUNDS = 512
	)
	(
		input  wire logic       clk,
		input  wire logic       arst_n,
		input  wire logic       s_axis_tvalid,
		output logic            s_axis_tready,
		input  wire logic [7:0] s_axis_tdata,  // [7:0] data_byte
		input  wire logic [2:0] s_axis_tuser,  // [2:0] mode
		output logic            m_axis_tvalid,
		input  wire logic       m_axis_tready,
		output logic      [7:0] m_axis_tdata   // [7:0] result_byte
	);

	localparam int CNT_W = (WHIP_ROUNDS > 1) ? $clog2(WHIP_ROUNDS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WHIP_ROUNDS - 1);

	seq_state_t state_q, state_d;

	logic [7:0] a_q, a_d;
	logic [7:0] i_q, i_d;
	logic [7:0] j_q, j_d;
	logic [7:0] k_q, k_d;
	logic [7:0] w_q, w_d;
	logic [7:0] z_q, z_d;
	logic [7:0] pi_q, pi_d;
	logic [2:0] mode_q, mode_d;
	logic [7:0] byte_q, byte_d;
	logic       nib_sel_q, nib_sel_d;
	logic       shuf_q, shuf_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic       out_valid_q, out_valid_d;
	logic [7:0] out_data_q, out_data_d;

	logic [TBL_DEPTH-1:0] valid_q;
	logic                 valid_clr;
	logic                 valid_s1;
	logic [TBL_AW-1:0]    raddr_s1;

	logic              ram_we;
	logic [TBL_AW-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [TBL_AW-1:0] ram_raddr;
	logic [7:0]        ram_rdata;
	logic [7:0]        rd;

	logic [3:0] nib;
	logic [7:0] swap_addr;
	logic [7:0] ks_mix;

	spse_ram #(
		.WIDTH(8),
		.DEPTH(TBL_DEPTH)
	) u_perm (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// An entry never written since init reads as its own index.
	assign rd = valid_s1 ? ram_rdata : raddr_s1;

	assign nib = nib_sel_q ? byte_q[7:4] : (byte_q[3:0] & NIBBLE_MASK[3:0]);
	assign swap_addr = HALF_POINT | {4'h0, nib};

	// Combine the output byte with the data word according to the mode.
	always_comb begin
		case (mode_q)
			MODE_ENCRYPT: ks_mix = byte_q + z_q;
			MODE_DECRYPT: ks_mix = byte_q - z_q;
			default:      ks_mix = z_q;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	// Next state and datapath updates.
	always_comb begin
		state_d = state_q;
		a_d = a_q;
		i_d = i_q;
		j_d = j_q;
		k_d = k_q;
		w_d = w_q;
		z_d = z_q;
		pi_d = pi_q;
		mode_d = mode_q;
		byte_d = byte_q;
		nib_sel_d = nib_sel_q;
		shuf_d = shuf_q;
		cnt_d = cnt_q;
		out_valid_d = out_valid_q && !m_axis_tready;
		out_data_d = out_data_q;
		valid_clr = 1'b0;
		ram_we = 1'b0;
		ram_waddr = a_q;
		ram_wdata = rd;
		ram_raddr = a_q;

		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					mode_d = s_axis_tuser;
					byte_d = s_axis_tdata;
					nib_sel_d = 1'b0;
					shuf_d = 1'b0;
					case (s_axis_tuser)
						MODE_INIT: begin
							valid_clr = 1'b1;
							a_d = 8'd0;
							i_d = 8'd0;
							j_d = 8'd0;
							k_d = 8'd0;
							w_d = STRIDE_RESET;
							z_d = 8'd0;
						end
						MODE_ABSORB: begin
							j_d = j_q + s_axis_tdata;
							state_d = ST_A_CHK;
						end
						MODE_STOP:    state_d = ST_STOP;
						MODE_DRIP:    state_d = ST_KEY;
						MODE_ENCRYPT: state_d = ST_KEY;
						MODE_DECRYPT: state_d = ST_KEY;
						MODE_PEEK:    state_d = ST_O_R1;
						default:      state_d = ST_IDLE;
					endcase
				end
			end

			// Absorb one nibble: shuffle when the absorb position is full.
			ST_A_CHK: begin
				if (a_q == HALF_POINT) begin
					shuf_d = 1'b1;
					cnt_d = '0;
					state_d = ST_U_RI;
				end else begin
					state_d = ST_A_R1;
				end
			end
			ST_A_R1: begin
				ram_raddr = a_q;
				state_d = ST_A_R2;
			end
			ST_A_R2: begin
				pi_d = rd;
				ram_raddr = swap_addr;
				state_d = ST_A_W1;
			end
			ST_A_W1: begin
				ram_we = 1'b1;
				ram_waddr = a_q;
				ram_wdata = rd;
				state_d = ST_A_W2;
			end
			ST_A_W2: begin
				ram_we = 1'b1;
				ram_waddr = swap_addr;
				ram_wdata = pi_q;
				a_d = a_q + 8'd1;
				if (nib_sel_q) begin
					state_d = ST_IDLE;
				end else begin
					nib_sel_d = 1'b1;
					state_d = ST_A_CHK;
				end
			end

			// Absorb stop.
			ST_STOP: begin
				if (a_q == HALF_POINT) begin
					shuf_d = 1'b1;
					cnt_d = '0;
					state_d = ST_U_RI;
				end else begin
					state_d = ST_STOP_FIN;
				end
			end
			ST_STOP_FIN: begin
				a_d = a_q + 8'd1;
				state_d = ST_IDLE;
			end

			// Keystream: shuffle first when anything is absorbed.
			ST_KEY: begin
				if (a_q != 8'd0) begin
					shuf_d = 1'b1;
					cnt_d = '0;
				end
				state_d = ST_U_RI;
			end

			// One update step: three dependent reads and a swap.
			ST_U_RI: begin
				i_d = i_q + w_q;
				ram_raddr = i_q + w_q;
				state_d = ST_U_RY;
			end
			ST_U_RY: begin
				pi_d = rd;
				ram_raddr = j_q + rd;
				state_d = ST_U_RJ;
			end
			ST_U_RJ: begin
				j_d = k_q + rd;
				ram_raddr = k_q + rd;
				state_d = ST_U_W1;
			end
			ST_U_W1: begin
				k_d = i_q + k_q + rd;
				ram_we = 1'b1;
				ram_waddr = i_q;
				ram_wdata = rd;
				state_d = ST_U_W2;
			end
			ST_U_W2: begin
				ram_we = 1'b1;
				ram_waddr = j_q;
				ram_wdata = pi_q;
				if (!shuf_q) begin
					state_d = ST_O_R1;
				end else if (cnt_q != CNT_LAST) begin
					cnt_d = cnt_q + 1'b1;
					state_d = ST_U_RI;
				end else begin
					shuf_d = 1'b0;
					w_d = w_q + STRIDE_STEP;
					a_d = 8'd0;
					case (mode_q)
						MODE_ABSORB: state_d = ST_A_R1;
						MODE_STOP:   state_d = ST_STOP_FIN;
						default:     state_d = ST_U_RI;
					endcase
				end
			end

			// Output step: three dependent reads.
			ST_O_R1: begin
				ram_raddr = z_q + k_q;
				state_d = ST_O_R2;
			end
			ST_O_R2: begin
				ram_raddr = i_q + rd;
				state_d = ST_O_R3;
			end
			ST_O_R3: begin
				ram_raddr = j_q + rd;
				state_d = ST_O_R4;
			end
			ST_O_R4: begin
				z_d = rd;
				state_d = ST_EMIT;
			end

			// Hand the result to the output register once it is free.
			ST_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_valid_d = 1'b1;
					out_data_d = ks_mix;
					state_d = ST_IDLE;
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			a_q <= 8'd0;
			i_q <= 8'd0;
			j_q <= 8'd0;
			k_q <= 8'd0;
			w_q <= STRIDE_RESET;
			z_q <= 8'd0;
			nib_sel_q <= 1'b0;
			shuf_q <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			a_q <= a_d;
			i_q <= i_d;
			j_q <= j_d;
			k_q <= k_d;
			w_q <= w_d;
			z_q <= z_d;
			nib_sel_q <= nib_sel_d;
			shuf_q <= shuf_d;
			cnt_q <= cnt_d;
			out_valid_q <= out_valid_d;
			if (valid_clr) begin
				valid_q <= '0;
			end else if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
		end
	end

	// Payload registers and the read-side valid tag.
	always_ff @(posedge clk) begin
		pi_q <= pi_d;
		mode_q <= mode_d;
		byte_q <= byte_d;
		out_data_q <= out_data_d;
		valid_s1 <= valid_q[ram_raddr];
		raddr_s1 <= ram_raddr;
	end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

import spse_pkg::*;

// Keeps a private copy of the sponge state, works out the byte that each
// accepted word should produce and checks the returned words in order.
class sponge_scoreboard;
	logic [7:0] perm[256];
	logic [7:0] absorb_pos;
	logic [7:0] pos_i;
	logic [7:0] pos_j;
	logic [7:0] pos_k;
	logic [7:0] stride;
	logic [7:0] last_z;
	int         whip_len;
	logic [7:0] expected_bytes[$];
	int         failures;

	function new(int whip_rounds);
		whip_len = whip_rounds;
		failures = 0;
		restart();
	endfunction

	function void restart();
		for (int v = 0; v < 256; v++) begin
			perm[v] = v[7:0];
		end
		absorb_pos = '0;
		pos_i = '0;
		pos_j = '0;
		pos_k = '0;
		stride = STRIDE_RESET;
		last_z = '0;
	endfunction

	function void swap_at(logic [7:0] p, logic [7:0] q);
		logic [7:0] t;
		t = perm[p];
		perm[p] = perm[q];
		perm[q] = t;
	endfunction

	// One update of the index registers, ending with a swap.
	function void stir();
		logic [7:0] y;
		pos_i = pos_i + stride;
		y = pos_j + perm[pos_i];
		pos_j = pos_k + perm[y];
		pos_k = pos_i + pos_k + perm[pos_j];
		swap_at(pos_i, pos_j);
	endfunction

	function logic [7:0] squeeze();
		logic [7:0] y1;
		logic [7:0] x1;
		logic [7:0] y2;
		y1 = last_z + pos_k;
		x1 = pos_i + perm[y1];
		y2 = pos_j + perm[x1];
		last_z = perm[y2];
		return last_z;
	endfunction

	function void whip();
		for (int n = 0; n < whip_len; n++) begin
			stir();
		end
		stride = stride + STRIDE_STEP;
		absorb_pos = '0;
	endfunction

	function void feed_nibble(logic [3:0] x);
		logic [7:0] partner;
		if (absorb_pos == HALF_POINT) begin
			whip();
		end
		partner = HALF_POINT + {4'b0000, x};
		swap_at(absorb_pos, partner);
		absorb_pos = absorb_pos + 8'd1;
	endfunction

	function logic [7:0] next_key();
		if (absorb_pos != 8'd0) begin
			whip();
		end
		stir();
		return squeeze();
	endfunction

	// Called for every word that the engine accepts.
	function void note_word(logic [2:0] mode, logic [7:0] data);
		logic [7:0] r;
		case (mode)
			MODE_INIT: begin
				restart();
			end
			MODE_ABSORB: begin
				pos_j = pos_j + data;
				feed_nibble(data[3:0]);
				feed_nibble(data[7:4]);
			end
			MODE_STOP: begin
				if (absorb_pos == HALF_POINT) begin
					whip();
				end
				absorb_pos = absorb_pos + 8'd1;
			end
			MODE_DRIP: begin
				r = next_key();
				expected_bytes.push_back(r);
			end
			MODE_ENCRYPT: begin
				r = data + next_key();
				expected_bytes.push_back(r);
			end
			MODE_DECRYPT: begin
				r = data - next_key();
				expected_bytes.push_back(r);
			end
			MODE_PEEK: begin
				r = squeeze();
				expected_bytes.push_back(r);
			end
			default: begin
			end
		endcase
	endfunction

	function void check_word(logic [7:0] got);
		logic [7:0] want;
		if (expected_bytes.size() == 0) begin
			$display("%0t: unexpected result word, expected none, actual %02h", $time, got);
			failures++;
		end else begin
			want = expected_bytes.pop_front();
			if (want !== got) begin
				$display("%0t: result mismatch, expected %02h, actual %02h", $time, want, got);
				failures++;
			end
		end
	endfunction
endclass

module tb_top;

	localparam int         SHUFFLE_ROUNDS = 512;
	localparam int         TOTAL_WORDS = 1850;
	localparam int         TAIL_WORDS = 150;
	// Long enough to cover a long key, two shuffles and the first output words.
	localparam int         LONG_HOLD = 12000;
	// A word with no result may still be running a shuffle when the last result is out.
	localparam int         DRAIN_CYCLES = 5 * SHUFFLE_ROUNDS + 40;
	localparam logic [2:0] MODE_UNUSED = 3'd7;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic [7:0] s_tdata = 8'h00;
	logic [2:0] s_tuser = MODE_INIT;
	logic       m_tready = 1'b0;
	wire        s_axis_tready;
	wire        m_axis_tvalid;
	wire  [7:0] m_axis_tdata;

	// Run control shared by the sender and the receiver.
	bit calm = 1'b0;
	bit quiet_tail = 1'b0;
	bit hold_req = 1'b0;
	int words_sent = 0;

	sponge_scoreboard sb = new(SHUFFLE_ROUNDS);

	spritz_sponge_engine_top #(
		.WHIP_ROUNDS(SHUFFLE_ROUNDS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_tdata),
		.s_axis_tuser(s_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Results are taken at the rising edge.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_tready) begin
			sb.check_word(m_axis_tdata);
		end
	end

	// Receiver: random stall bursts, one long hold-off on request, none at the tail or while calm.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (!quiet_tail && !calm && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 5);
				m_tready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offers one word, with an occasional idle burst first, and waits for its acceptance.
	task automatic send_word(input logic [2:0] mode, input logic [7:0] data);
		int gap;
		if (!quiet_tail && !calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= data;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_word(mode, data);
		if (mode != MODE_UNUSED) begin
			words_sent++;
		end
	endtask

	// A keyed session: optional init, some absorbed bytes, optional stops, then output words.
	task automatic run_session();
		int n_abs;
		int n_out;
		if ($urandom_range(0, 3) == 0) begin
			send_word(MODE_INIT, 8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 7) == 0) begin
			// Long keys land exactly on the half point or run past it.
			n_abs = ($urandom_range(0, 1) == 0) ? 64 : $urandom_range(65, 80);
		end else begin
			n_abs = $urandom_range(1, 16);
		end
		repeat (n_abs) send_word(MODE_ABSORB, 8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, 2)) send_word(MODE_STOP, 8'($urandom_range(0, 255)));
		n_out = $urandom_range(6, 30);
		repeat (n_out) begin
			send_word(3'($urandom_range(int'(MODE_DRIP), int'(MODE_PEEK))),
				8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		bit hold_done;
		int guard;
		hold_done = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words: reset state, byte extremes, every mode and the ignored code.
		send_word(MODE_PEEK, 8'h00);
		send_word(MODE_DRIP, 8'hff);
		send_word(MODE_ENCRYPT, 8'h00);
		send_word(MODE_ENCRYPT, 8'hff);
		send_word(MODE_DECRYPT, 8'h00);
		send_word(MODE_DECRYPT, 8'hff);
		send_word(MODE_UNUSED, 8'hff);
		send_word(MODE_UNUSED, 8'h00);
		send_word(MODE_ABSORB, 8'h00);
		send_word(MODE_ABSORB, 8'hff);
		send_word(MODE_ABSORB, 8'h5a);
		// Peek while bytes are pending must not shuffle.
		send_word(MODE_PEEK, 8'h33);
		send_word(MODE_STOP, 8'h00);
		send_word(MODE_DRIP, 8'h00);
		send_word(MODE_DECRYPT, 8'h80);
		send_word(MODE_INIT, 8'hff);
		send_word(MODE_ABSORB, 8'h01);
		send_word(MODE_STOP, 8'hff);
		send_word(MODE_STOP, 8'h00);
		send_word(MODE_ENCRYPT, 8'h7f);
		send_word(MODE_PEEK, 8'h00);
		send_word(MODE_DRIP, 8'h00);
		send_word(MODE_INIT, 8'h00);

		// Random part: mostly keyed sessions, some words of pure noise.
		while (words_sent < TOTAL_WORDS) begin
			quiet_tail = (words_sent >= TOTAL_WORDS - TAIL_WORDS);
			calm = ($urandom_range(0, 3) == 0);
			if (!hold_done && words_sent > 300) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(3, 10)) begin
					send_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
				end
			end else begin
				run_session();
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		// Wait for the outstanding results, then let any last shuffle finish.
		guard = 0;
		while (sb.expected_bytes.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.expected_bytes.size() != 0) begin
			$display("%0t: %0d result words never arrived, expected %02h first, actual none",
				$time, sb.expected_bytes.size(), sb.expected_bytes[0]);
			sb.failures++;
		end
		if (sb.failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Far above the slowest run: some dozens of shuffles plus stalls.
	initial begin
		#100000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
